[rtl/line_line_intersection_2d_defines.svh]
// ----------------------------------------------------------------------------
// Line intersection assertion macros
// Shared concurrent assertion forms for the intersection block.
// ----------------------------------------------------------------------------
`ifndef LINE_LINE_INTERSECTION_2D_DEFINES_SVH
`define LINE_LINE_INTERSECTION_2D_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LLI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line intersection check failed");

// Next-cycle implication, checked out of reset.
`define LLI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line intersection check failed");

`endif

[rtl/lli_pkg.sv]
// ----------------------------------------------------------------------------
// Line intersection package
// Shared types and default constants of the intersection block.
// ----------------------------------------------------------------------------
package lli_pkg;

  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned OutBitsDef   = 24;
  localparam int unsigned ThrBits      = 32;
  localparam logic [ThrBits-1:0] ThrReset = 32'd1;

  // Bit positions of the result flags in the output tuser.
  localparam int unsigned UserFound = 0;
  localparam int unsigned UserClip  = 1;
  localparam int unsigned UserBits  = 2;

  // Control that travels beside the data from the chain entry through every divider cell.
  typedef struct packed {
    logic valid;
    logic found;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } lli_ctl_t;

endpackage

[rtl/lli_front.sv]
// ----------------------------------------------------------------------------
// Line intersection front end
// Forms the line coefficients, determinant and numerators, decides whether
// the lines are parallel and prepares magnitudes for the divider chain.
// ----------------------------------------------------------------------------
module lli_front
  import lli_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned OUT_BITS   = OutBitsDef,
  localparam int unsigned DW   = COORD_BITS + 1,
  localparam int unsigned DETW = 2 * DW + 1,
  localparam int unsigned NW   = 3 * DW + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [8*COORD_BITS-1:0] coord_i,
  input  logic [ThrBits-1:0]      thr_i,
  output lli_ctl_t                ctl_o,
  output logic [NW-1:0]           rx_o,
  output logic [NW-1:0]           ry_o,
  output logic [DETW-1:0]         d_o
);

  localparam int unsigned CW  = COORD_BITS;
  localparam int unsigned CCW = 2 * DW;
  localparam int unsigned EW  = NW + OUT_BITS;
  localparam int unsigned TW  = (DETW > ThrBits) ? DETW : ThrBits;

  logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  assign ax = coord_i[0*CW +: CW];
  assign ay = coord_i[1*CW +: CW];
  assign bx = coord_i[2*CW +: CW];
  assign by = coord_i[3*CW +: CW];
  assign cx = coord_i[4*CW +: CW];
  assign cy = coord_i[5*CW +: CW];
  assign dx = coord_i[6*CW +: CW];
  assign dy = coord_i[7*CW +: CW];

  logic [6:0] v_q;

  // Stage 1: line coefficients.
  logic signed [DW-1:0] a1_q, b1_q, a2_q, b2_q;
  logic signed [CW-1:0] ax_q, ay_q, cx_q, cy_q;
  // Stage 2: products.
  logic signed [DW-1:0]   a1_2q, b1_2q, a2_2q, b2_2q;
  logic signed [2*CW:0]   pa1_q, pb1_q, pa2_q, pb2_q;
  logic signed [2*DW-1:0] pd1_q, pd2_q;
  // Stage 3: line constants and determinant.
  logic signed [DW-1:0]   a1_3q, b1_3q, a2_3q, b2_3q;
  logic signed [CCW-1:0]  c1_q, c2_q;
  logic signed [DETW-1:0] det3_q;
  // Stage 4: numerator products.
  logic signed [3*DW-1:0] m1_q, m2_q, m3_q, m4_q;
  logic signed [DETW-1:0] det4_q;
  // Stage 5: numerators and parallel decision.
  logic signed [NW-1:0]   nx_q, ny_q;
  logic signed [DETW-1:0] det5_q;
  logic                   par_q;
  // Stage 6: magnitudes.
  logic [NW-1:0]   mx_q, my_q;
  logic [DETW-1:0] md_q;
  logic            sx_q, sy_q, par6_q;
  // Stage 7: chain entry.
  lli_ctl_t        ctl_q;
  logic [NW-1:0]   rx_q, ry_q;
  logic [DETW-1:0] d_q;

  logic [DETW-1:0] det_mag;
  logic [EW-1:0]   dsh;

  assign det_mag = det4_q[DETW-1] ? DETW'(-det4_q) : DETW'(det4_q);
  assign dsh     = EW'(md_q) << OUT_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q <= DW'(by) - DW'(ay);
      b1_q <= DW'(ax) - DW'(bx);
      a2_q <= DW'(dy) - DW'(cy);
      b2_q <= DW'(cx) - DW'(dx);
      ax_q <= ax;
      ay_q <= ay;
      cx_q <= cx;
      cy_q <= cy;

      a1_2q <= a1_q;
      b1_2q <= b1_q;
      a2_2q <= a2_q;
      b2_2q <= b2_q;
      pa1_q <= a1_q * ax_q;
      pb1_q <= b1_q * ay_q;
      pa2_q <= a2_q * cx_q;
      pb2_q <= b2_q * cy_q;
      pd1_q <= a1_q * b2_q;
      pd2_q <= a2_q * b1_q;

      a1_3q  <= a1_2q;
      b1_3q  <= b1_2q;
      a2_3q  <= a2_2q;
      b2_3q  <= b2_2q;
      c1_q   <= CCW'(pa1_q) + CCW'(pb1_q);
      c2_q   <= CCW'(pa2_q) + CCW'(pb2_q);
      det3_q <= DETW'(pd1_q) - DETW'(pd2_q);

      m1_q   <= b2_3q * c1_q;
      m2_q   <= b1_3q * c2_q;
      m3_q   <= a1_3q * c2_q;
      m4_q   <= a2_3q * c1_q;
      det4_q <= det3_q;

      nx_q   <= NW'(m1_q) - NW'(m2_q);
      ny_q   <= NW'(m3_q) - NW'(m4_q);
      det5_q <= det4_q;
      par_q  <= (det4_q == '0) || (TW'(det_mag) < TW'(thr_i));

      mx_q   <= nx_q[NW-1] ? NW'(-nx_q) : NW'(nx_q);
      my_q   <= ny_q[NW-1] ? NW'(-ny_q) : NW'(ny_q);
      md_q   <= det5_q[DETW-1] ? DETW'(-det5_q) : DETW'(det5_q);
      sx_q   <= nx_q[NW-1] ^ det5_q[DETW-1];
      sy_q   <= ny_q[NW-1] ^ det5_q[DETW-1];
      par6_q <= par_q;

      // A numerator at or above the divisor shifted past the output width
      // gives a quotient that cannot be held and always saturates.
      ctl_q.valid <= v_q[5];
      ctl_q.found <= !par6_q;
      ctl_q.neg_x <= sx_q;
      ctl_q.neg_y <= sy_q;
      ctl_q.ovf_x <= EW'(mx_q) >= dsh;
      ctl_q.ovf_y <= EW'(my_q) >= dsh;
      rx_q <= mx_q;
      ry_q <= my_q;
      d_q  <= md_q;
    end
  end

  always_comb begin
    ctl_o       = ctl_q;
    ctl_o.valid = v_q[6];
  end

  assign rx_o = rx_q;
  assign ry_o = ry_q;
  assign d_o  = d_q;

endmodule

[rtl/lli_div_cell.sv]
// ----------------------------------------------------------------------------
// Line intersection divider cell
// One restoring division step for both coordinates against the shared
// determinant magnitude; produces one quotient bit per lane.
// ----------------------------------------------------------------------------
module lli_div_cell
  import lli_pkg::*;
#(
  parameter int unsigned NW    = 52,
  parameter int unsigned DETW  = 35,
  parameter int unsigned OW    = OutBitsDef,
  parameter int unsigned SHIFT = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  lli_ctl_t        ctl_i,
  input  logic [NW-1:0]   rx_i,
  input  logic [NW-1:0]   ry_i,
  input  logic [DETW-1:0] d_i,
  input  logic [OW-1:0]   qx_i,
  input  logic [OW-1:0]   qy_i,
  output lli_ctl_t        ctl_o,
  output logic [NW-1:0]   rx_o,
  output logic [NW-1:0]   ry_o,
  output logic [DETW-1:0] d_o,
  output logic [OW-1:0]   qx_o,
  output logic [OW-1:0]   qy_o
);

  localparam int unsigned EW = NW + OW;

  logic [EW-1:0] dsh;
  logic          bit_x, bit_y;

  assign dsh   = EW'(d_i) << SHIFT;
  assign bit_x = EW'(rx_i) >= dsh;
  assign bit_y = EW'(ry_i) >= dsh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else if (en_i) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_o <= bit_x ? rx_i - dsh[NW-1:0] : rx_i;
      ry_o <= bit_y ? ry_i - dsh[NW-1:0] : ry_i;
      d_o  <= d_i;
      qx_o <= {qx_i[OW-2:0], bit_x};
      qy_o <= {qy_i[OW-2:0], bit_y};
    end
  end

endmodule

[rtl/line_line_intersection_2d.sv]
// ----------------------------------------------------------------------------
// Line-line intersection, 2D
// Intersects line AB with line CD by Cramer's rule in exact fixed point.
//
// Channel   Dir  Beat contents (low bit first)
// s_axis    in   tdata: a_x a_y b_x b_y c_x c_y d_x d_y
// m_axis    out  tdata: cross_x cross_y; tuser: found clipped
// cfg       in   parallel_threshold, written when cfg_we_i is high
//
// One beat is accepted per cycle while the output is not stalled. The pipeline is
// seven stages of multiply and compare, then one divider cell per quotient bit,
// then the saturating output register.
// Reset clears every valid bit and loads the threshold with 1.
// A stalled output beat freezes the whole pipeline and drops s_axis_tready.
// ----------------------------------------------------------------------------
`include "line_line_intersection_2d_defines.svh"

module line_line_intersection_2d
  import lli_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned OUT_BITS   = OutBitsDef,
  localparam int unsigned ODW = ((2 * OUT_BITS + 7) / 8) * 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [8*COORD_BITS-1:0] s_axis_tdata,   // a_x a_y b_x b_y c_x c_y d_x d_y
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [ODW-1:0]          m_axis_tdata,   // cross_x cross_y
  output logic [UserBits-1:0]     m_axis_tuser,   // found clipped
  input  logic                    cfg_we_i,
  input  logic [ThrBits-1:0]      cfg_wdata_i
);

  localparam int unsigned OW   = OUT_BITS;
  localparam int unsigned DW   = COORD_BITS + 1;
  localparam int unsigned DETW = 2 * DW + 1;
  localparam int unsigned NW   = 3 * DW + 1;
  localparam logic [OW-1:0] LimPos = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] LimNeg = {1'b1, {(OW-1){1'b0}}};

  logic [ThrBits-1:0] thr_q;
  logic               en;

  lli_ctl_t        ctl_c [OW+1];
  logic [NW-1:0]   rx_c  [OW+1];
  logic [NW-1:0]   ry_c  [OW+1];
  logic [DETW-1:0] d_c   [OW+1];
  logic [OW-1:0]   qx_c  [OW+1];
  logic [OW-1:0]   qy_c  [OW+1];

  logic              out_valid_q;
  logic [OW-1:0]     cx_q, cy_q;
  logic              found_q, clip_q;
  logic [OW:0]       sat_x, sat_y;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  lli_front #(
    .COORD_BITS (COORD_BITS),
    .OUT_BITS   (OUT_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .coord_i (s_axis_tdata),
    .thr_i   (thr_q),
    .ctl_o   (ctl_c[0]),
    .rx_o    (rx_c[0]),
    .ry_o    (ry_c[0]),
    .d_o     (d_c[0])
  );

  assign qx_c[0] = '0;
  assign qy_c[0] = '0;

  // The first cell resolves the top quotient bit.
  for (genvar k = 0; k < OW; k++) begin : g_cell
    lli_div_cell #(
      .NW    (NW),
      .DETW  (DETW),
      .OW    (OW),
      .SHIFT (OW - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl_c[k]),
      .rx_i   (rx_c[k]),
      .ry_i   (ry_c[k]),
      .d_i    (d_c[k]),
      .qx_i   (qx_c[k]),
      .qy_i   (qy_c[k]),
      .ctl_o  (ctl_c[k+1]),
      .rx_o   (rx_c[k+1]),
      .ry_o   (ry_c[k+1]),
      .d_o    (d_c[k+1]),
      .qx_o   (qx_c[k+1]),
      .qy_o   (qy_c[k+1])
    );
  end

  // Returns {clip, value}; a zero quotient is never negative.
  function automatic logic [OW:0] sat(input logic [OW-1:0] q, input logic neg,
                                      input logic ovf);
    logic [OW:0] r;
    if (neg && q != '0) begin
      if (ovf || q > LimNeg) begin
        r = {1'b1, LimNeg};
      end else begin
        r = {1'b0, OW'(-q)};
      end
    end else begin
      if (ovf || q > LimPos) begin
        r = {1'b1, LimPos};
      end else begin
        r = {1'b0, q};
      end
    end
    return r;
  endfunction

  assign sat_x = sat(qx_c[OW], ctl_c[OW].neg_x, ctl_c[OW].ovf_x);
  assign sat_y = sat(qy_c[OW], ctl_c[OW].neg_y, ctl_c[OW].ovf_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctl_c[OW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      found_q <= ctl_c[OW].found;
      if (ctl_c[OW].found) begin
        cx_q   <= sat_x[OW-1:0];
        cy_q   <= sat_y[OW-1:0];
        clip_q <= sat_x[OW] | sat_y[OW];
      end else begin
        cx_q   <= '0;
        cy_q   <= '0;
        clip_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ODW'({cy_q, cx_q});
  always_comb begin
    m_axis_tuser            = '0;
    m_axis_tuser[UserFound] = found_q;
    m_axis_tuser[UserClip]  = clip_q;
  end

  `LLI_ASSERT_NOW(a_parallel_zero, m_axis_tvalid && !m_axis_tuser[UserFound],
                  m_axis_tdata == '0 && !m_axis_tuser[UserClip])
  `LLI_ASSERT_NOW(a_clip_at_limit, m_axis_tvalid && m_axis_tuser[UserClip],
                  cx_q == LimPos || cx_q == LimNeg || cy_q == LimPos || cy_q == LimNeg)
  `LLI_ASSERT_NOW(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `LLI_ASSERT_NEXT(a_stall_freezes, m_axis_tvalid && !m_axis_tready,
                   $stable(ctl_c[OW]) && $stable(qx_c[OW]))

endmodule
